// ----- src/checked_hex_dec_text_to_int_core_macros.svh -----
// Assertion macros shared by the text-to-integer converter RTL.
// Expects clk and rst_n in scope at each use; no other dependencies.
`ifndef CHECKED_HEX_DEC_TEXT_TO_INT_CORE_MACROS_SVH
`define CHECKED_HEX_DEC_TEXT_TO_INT_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CHDTI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define CHDTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/chdti_pkg.sv -----
// Shared types and constants for the text-to-integer converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package chdti_pkg;

  // Character codes the parser reacts to
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_X  = 8'h78;

  // Letter digits: low nibble of 'A'..'F' / 'a'..'f' plus this gives 10..15
  localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

  // Register map
  localparam int          PADDR_W          = 3;
  localparam logic        REG_REJECT_INVAL = 1'b0;  // word index, paddr[2]
  localparam int          OUT_W            = 32;

  // Character queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Parser phase
  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_HEX    = 3'd3,
    PH_DEC    = 3'd4
  } chdti_phase_t;

  // Pre-decoded character
  typedef struct packed {
    logic       term;    // zero byte
    logic       minus;
    logic       plus;
    logic       zero;    // '0'
    logic       xchar;   // 'x' or 'X'
    logic       dec_ok;  // '0'..'9'
    logic       hex_ok;  // '0'..'9', 'A'..'F', 'a'..'f'
    logic [3:0] digit;   // digit value when dec_ok or hex_ok
  } chdti_class_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic rd_valid;
  } chdti_qstat_t;

endpackage

`default_nettype wire

// ----- src/checked_hex_dec_text_to_int_core.sv -----
// Top level of the streaming text-to-integer converter with hex prefix.
// Depends on chdti_pkg, chdti_front, chdti_queue and chdti_back.
`timescale 1ns / 1ps
`default_nettype none

// Takes one character per cycle on the input channel while the queue has
// room; a zero byte ends the string and yields one result (value and ok
// flag) on the output channel. Characters are decoded in the front end,
// pass a two-entry queue and are folded into the accumulator by the back
// end, one per cycle unless a terminator waits, so the sustained rate is one
// character per clock. A terminator passes the queue and its result then
// sits in the result register; that single register is the only point that
// can hold the back end, and only for terminators.
// No start-up sweep: the block takes characters right after reset.
// Register reject_invalid (byte address 0, reset 1) selects strict mode and
// is meant to be written between strings.

module checked_hex_dec_text_to_int_core import chdti_pkg::*; #(
  parameter int ACC_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // Character channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           in_char_byte,
  // Result channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [OUT_W-1:0]   out_int_value,
  output logic                      out_ok,
  // Register port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic          reject_r, reject_nxt;
  logic          reg_sel;
  chdti_qstat_t  qstat;
  chdti_class_t  push_data;
  chdti_class_t  rd_data;
  logic          push;
  logic          pop;

  // Register port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_REJECT_INVAL);
  assign prdata  = reg_sel ? {31'b0, reject_r} : 32'b0;

  always_comb begin
    reject_nxt = reject_r;
    if (psel && penable && pwrite && reg_sel) begin
      reject_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reject_r <= 1'b1;
    end else begin
      reject_r <= reject_nxt;
    end
  end

  // Front: accept and decode
  chdti_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_byte (in_char_byte),
    .qstat        (qstat),
    .push         (push),
    .push_data    (push_data)
  );

  // Decoded character queue
  chdti_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (rd_data),
    .qstat     (qstat)
  );

  // Back: parse and emit
  chdti_back #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .reject_invalid (reject_r),
    .qstat          (qstat),
    .rd_data        (rd_data),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_int_value  (out_int_value),
    .out_ok         (out_ok)
  );

endmodule

`default_nettype wire

// ----- src/chdti_front.sv -----
// Front end: accepts character requests and decodes each into a class word.
// Depends on chdti_pkg; feeds chdti_queue.
`timescale 1ns / 1ps
`default_nettype none

module chdti_front import chdti_pkg::*; (
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_char_byte,
  input  wire chdti_qstat_t qstat,
  output logic              push,
  output chdti_class_t      push_data
);

  logic is_dec;
  logic is_up;
  logic is_lo;

  // Take a character whenever the queue has room
  assign in_ready = !qstat.full;
  assign push     = in_valid && !qstat.full;

  // Character classes
  assign is_dec = (in_char_byte >= CH_ZERO) && (in_char_byte <= CH_NINE);
  assign is_up  = (in_char_byte >= CH_UP_A) && (in_char_byte <= CH_UP_F);
  assign is_lo  = (in_char_byte >= CH_LO_A) && (in_char_byte <= CH_LO_F);

  always_comb begin
    push_data.term   = (in_char_byte == CH_NUL);
    push_data.minus  = (in_char_byte == CH_MINUS);
    push_data.plus   = (in_char_byte == CH_PLUS);
    push_data.zero   = (in_char_byte == CH_ZERO);
    push_data.xchar  = (in_char_byte == CH_UP_X) || (in_char_byte == CH_LO_X);
    push_data.dec_ok = is_dec;
    push_data.hex_ok = is_dec || is_up || is_lo;
    // letters: low nibble 1..6 maps to 10..15
    push_data.digit  = is_dec ? in_char_byte[3:0] : (in_char_byte[3:0] + HEX_LETTER_OFS);
  end

endmodule

`default_nettype wire

// ----- src/chdti_queue.sv -----
// Two-entry queue of decoded characters between front and back.
// Depends on chdti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chdti_queue import chdti_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire chdti_class_t push_data,
  input  wire logic         pop,
  output chdti_class_t      rd_data,
  output chdti_qstat_t      qstat
);

  chdti_class_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]        cnt_r, cnt_nxt;

  assign qstat.full     = (cnt_r == QCNT_W'(QDEPTH));
  assign qstat.rd_valid = (cnt_r != '0);
  assign rd_data        = mem_r[rd_ptr_r];

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- src/chdti_back.sv -----
// Back end: phase machine, shift-add accumulator and result register.
// Depends on chdti_pkg and the assertion macros header; reads chdti_queue.
`timescale 1ns / 1ps
`default_nettype none
`include "checked_hex_dec_text_to_int_core_macros.svh"

module chdti_back import chdti_pkg::*; #(
  parameter int ACC_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  reject_invalid,
  input  wire chdti_qstat_t          qstat,
  input  wire chdti_class_t          rd_data,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [OUT_W-1:0]    out_int_value,
  output logic                       out_ok
);

  chdti_phase_t          phase_r, phase_nxt;
  logic                  neg_r, neg_nxt;
  logic                  failed_r, failed_nxt;
  logic [ACC_WIDTH-1:0]  acc_r, acc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]      out_int_value_r;
  logic                  out_ok_r;

  logic                  work;       // non-terminator popped while not failed
  logic                  finish;     // terminator popped
  logic [ACC_WIDTH-1:0]  acc_dec;
  logic [ACC_WIDTH-1:0]  acc_hex;
  logic [ACC_WIDTH-1:0]  signed_acc;
  logic [OUT_W-1:0]      result_ext;

  // A terminator waits for the result register; other characters never stall
  assign pop    = qstat.rd_valid && (!rd_data.term || !out_valid_r || out_ready);
  assign finish = pop && rd_data.term;
  assign work   = pop && !rd_data.term && !failed_r;

  // Digit append: x10 as x8 + x2, x16 as a shift
  assign acc_dec = (acc_r << 3) + (acc_r << 1) + ACC_WIDTH'(rd_data.digit);
  assign acc_hex = (acc_r << 4) | ACC_WIDTH'(rd_data.digit);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (finish) begin
      phase_nxt = PH_START;
    end else if (work) begin
      unique case (phase_r)
        PH_START: begin
          if (rd_data.minus || rd_data.plus) begin
            phase_nxt = PH_SIGNED;
          end else begin
            phase_nxt = rd_data.zero ? PH_ZERO : PH_DEC;
          end
        end
        PH_SIGNED: begin
          phase_nxt = rd_data.zero ? PH_ZERO : PH_DEC;
        end
        PH_ZERO: begin
          phase_nxt = rd_data.xchar ? PH_HEX : PH_DEC;
        end
        PH_HEX: begin
          phase_nxt = PH_HEX;
        end
        PH_DEC: begin
          phase_nxt = PH_DEC;
        end
        default: begin
          phase_nxt = PH_DEC;
        end
      endcase
    end
  end

  // Datapath actions per phase
  always_comb begin
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    failed_nxt = failed_r;
    if (finish) begin
      acc_nxt    = '0;
      neg_nxt    = 1'b0;
      failed_nxt = 1'b0;
    end else if (work) begin
      unique case (phase_r)
        PH_START, PH_SIGNED: begin
          if ((phase_r == PH_START) && rd_data.minus) begin
            neg_nxt = 1'b1;
          end else if ((phase_r == PH_START) && rd_data.plus) begin
            neg_nxt = neg_r;
          end else if (!rd_data.zero) begin
            // first body character other than '0' is parsed as decimal
            if (rd_data.dec_ok) begin
              acc_nxt = acc_dec;
            end else if (reject_invalid) begin
              failed_nxt = 1'b1;
            end
          end
        end
        PH_ZERO: begin
          if (!rd_data.xchar) begin
            if (rd_data.dec_ok) begin
              acc_nxt = acc_dec;
            end else if (reject_invalid) begin
              failed_nxt = 1'b1;
            end
          end
        end
        PH_HEX: begin
          if (rd_data.hex_ok) begin
            acc_nxt = acc_hex;
          end else if (reject_invalid) begin
            failed_nxt = 1'b1;
          end
        end
        default: begin
          if (rd_data.dec_ok) begin
            acc_nxt = acc_dec;
          end else if (reject_invalid) begin
            failed_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  // Apply sign, then sign-extend or truncate to the output width
  assign signed_acc = neg_r ? (~acc_r + ACC_WIDTH'(1)) : acc_r;

  for (genvar i = 0; i < OUT_W; i++) begin : g_ext
    if (i < ACC_WIDTH) begin : g_bit
      assign result_ext[i] = signed_acc[i];
    end else begin : g_sign
      assign result_ext[i] = signed_acc[ACC_WIDTH-1];
    end
  end

  // Result register
  assign out_valid_nxt = finish || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      neg_r       <= 1'b0;
      failed_r    <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      failed_r    <= failed_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_int_value_r <= failed_r ? '0 : result_ext;
      out_ok_r        <= !failed_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_int_value = out_int_value_r;
  assign out_ok        = out_ok_r;

  // Checks
  `CHDTI_ASSERT_NOW(a_reject_zero, out_valid_r && !out_ok_r, out_int_value_r == '0, "rejected result not zero")
  `CHDTI_ASSERT_NEXT(a_finish_shows, finish, out_valid_r, "terminator gave no result")
  `CHDTI_ASSERT_NEXT(a_finish_clears, finish, (phase_r == PH_START) && !failed_r && (acc_r == '0), "state not cleared after result")
  `CHDTI_ASSERT_NEXT(a_failed_holds, failed_r && !finish, failed_r && $stable(acc_r), "failed string changed state")

endmodule

`default_nettype wire

// ----- sim/checked_hex_dec_text_to_int_core_test.sv -----
// Self-checking testbench for the streaming text-to-integer converter.
// Depends on chdti_pkg and checked_hex_dec_text_to_int_core; needs nothing else.
`timescale 1ns / 1ps

module checked_hex_dec_text_to_int_core_test import chdti_pkg::*;;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int STALL_LIMIT     = 5000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int MAX_PRINTED     = 40;
  localparam int PHASE_CHARS     = 350;
  localparam int NUM_PHASES      = 5;
  localparam logic [4:0] DEC_BASE = 5'd10;
  localparam logic [4:0] HEX_BASE = 5'd16;
  localparam logic [PADDR_W-1:0] REJECT_ADDR = PADDR_W'(4 * int'(REG_REJECT_INVAL));

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    ok;
  } parse_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_char_byte = 8'h00;
  logic out_ready = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire in_ready;
  wire out_valid;
  wire signed [OUT_W-1:0] out_int_value;
  wire out_ok;
  wire [31:0] prdata;
  wire pready;

  checked_hex_dec_text_to_int_core u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_char_byte  (in_char_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_int_value (out_int_value),
    .out_ok        (out_ok),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Characters waiting to be sent and parses waiting to come out
  logic [7:0]    char_queue[$];
  parse_result_t parse_queue[$];

  int err_count = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int stall_left = 0;
  int in_gap = 0;
  int in_calm = 0;
  int out_calm = 0;
  int quiet_cycles = 0;

  // Parser state mirror
  chdti_phase_t prs_phase = PH_START;
  logic         prs_neg = 1'b0;
  logic [31:0]  prs_acc = '0;
  logic         prs_failed = 1'b0;
  logic         strict_mode = 1'b1;

  task automatic flag_mismatch(input string what);
    if (err_count < MAX_PRINTED)
      $display("ERROR @%0t: %s", $time, what);
    err_count++;
  endtask

  function automatic void reject_char();
    if (strict_mode)
      prs_failed = 1'b1;
  endfunction

  function automatic void fold_digit(input logic [4:0] base, input logic [7:0] d);
    prs_acc = prs_acc * 32'(base) + 32'(d);
  endfunction

  function automatic void fold_dec(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE)
      fold_digit(DEC_BASE, c - CH_ZERO);
    else
      reject_char();
  endfunction

  function automatic void fold_hex(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE)
      fold_digit(HEX_BASE, c - CH_ZERO);
    else if (c >= CH_UP_A && c <= CH_UP_F)
      fold_digit(HEX_BASE, c - CH_UP_A + 8'd10);
    else if (c >= CH_LO_A && c <= CH_LO_F)
      fold_digit(HEX_BASE, c - CH_LO_A + 8'd10);
    else
      reject_char();
  endfunction

  // First character of the number body: a '0' may open a hex prefix
  function automatic void first_body(input logic [7:0] c);
    if (c == CH_ZERO) begin
      prs_phase = PH_ZERO;
    end else begin
      prs_phase = PH_DEC;
      fold_dec(c);
    end
  endfunction

  // Advance the mirror by one character; a terminator queues one parse
  function automatic void parse_char(input logic [7:0] c);
    parse_result_t res;
    if (c == CH_NUL) begin
      res.ok    = !prs_failed;
      res.value = prs_failed ? '0 : (prs_neg ? -prs_acc : prs_acc);
      parse_queue.push_back(res);
      prs_phase  = PH_START;
      prs_neg    = 1'b0;
      prs_acc    = '0;
      prs_failed = 1'b0;
    end else if (!prs_failed) begin
      case (prs_phase)
        PH_START: begin
          if (c == CH_MINUS) begin
            prs_neg   = 1'b1;
            prs_phase = PH_SIGNED;
          end else if (c == CH_PLUS) begin
            prs_phase = PH_SIGNED;
          end else begin
            first_body(c);
          end
        end
        PH_SIGNED: first_body(c);
        PH_ZERO: begin
          if (c == CH_LO_X || c == CH_UP_X) begin
            prs_phase = PH_HEX;
          end else begin
            prs_phase = PH_DEC;
            fold_dec(c);
          end
        end
        PH_HEX: fold_hex(c);
        default: begin
          prs_phase = PH_DEC;
          fold_dec(c);
        end
      endcase
    end
  endfunction

  // Gap length: mostly none or short, a few long, with calm stretches of none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      char_queue.push_back(s[i]);
    char_queue.push_back(CH_NUL);
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10)
      return CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(v - 10);
  endfunction

  // One random string plus terminator; returns the number of bytes queued
  function automatic int push_random_text();
    int kind, n, glitch_at, start;
    logic is_hex;
    start = char_queue.size();
    kind = $urandom_range(0, 99);
    if (kind >= 88) begin
      // raw noise
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++)
        char_queue.push_back(8'($urandom_range(1, 255)));
    end else begin
      case ($urandom_range(0, 3))
        0: char_queue.push_back(CH_MINUS);
        1: char_queue.push_back(CH_PLUS);
        default: ;
      endcase
      is_hex = ($urandom_range(0, 99) < 45);
      if (is_hex) begin
        char_queue.push_back(CH_ZERO);
        char_queue.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
        n = $urandom_range(0, 10);
      end else begin
        n = $urandom_range(1, 12);
      end
      // broken strings carry one stray byte somewhere in the digits
      glitch_at = (kind < 20) ? $urandom_range(0, n) : -1;
      for (int i = 0; i <= n; i++) begin
        if (i == glitch_at)
          char_queue.push_back(8'($urandom_range(1, 255)));
        if (i < n)
          char_queue.push_back(is_hex ? rand_hex_char() : CH_ZERO + 8'($urandom_range(0, 9)));
      end
    end
    char_queue.push_back(CH_NUL);
    return char_queue.size() - start;
  endfunction

  // Register write followed by a readback
  task automatic write_strict(input logic v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REJECT_ADDR;
    pwdata  <= {31'b0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    strict_mode = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[0] !== v)
      flag_mismatch($sformatf("reject_invalid readback: expected %0b, got %0b", v, prdata[0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Block is idle once all characters are in and all parses are out;
  // sampled mid-cycle so the driver's edge updates have settled
  task automatic wait_idle();
    do @(negedge clk); while (char_queue.size() != 0 || in_valid || parse_queue.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Character driver: new request only when the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready)
        parse_char(in_char_byte);
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (char_queue.size() > 0) begin
          in_char_byte <= char_queue.pop_front();
          in_valid <= 1'b1;
          in_gap = pick_gap(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk) begin
    parse_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (parse_queue.size() == 0) begin
          flag_mismatch($sformatf("result %0d/%0b with no string pending", out_int_value, out_ok));
        end else begin
          want = parse_queue.pop_front();
          if (out_int_value !== want.value)
            flag_mismatch($sformatf("int_value: expected %0d, got %0d", want.value, out_int_value));
          if (out_ok !== want.ok)
            flag_mismatch($sformatf("ok: expected %0b, got %0b", want.ok, out_ok));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        stall_left = HOLD_OFF_CYCLES;
        out_ready <= 1'b0;
      end else begin
        stall_left = pick_gap(out_calm);
        out_ready <= (stall_left == 0);
      end
    end
  end

  // Watchdog on cycles with no request moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin
    int pushed;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed strings in strict mode (reset value)
    push_text("");
    push_text("-");
    push_text("+");
    push_text("0x");
    push_text("0XaF");
    push_text("-09");
    push_text("1-5");
    char_queue.push_back(8'hFF);
    push_text("5");
    wait_idle();

    // Random phases alternating lenient and strict
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_strict((p % 2) != 0);
      // receiver holds off once while characters keep coming
      if (p == 2)
        hold_requests++;
      pushed = 0;
      while (pushed < PHASE_CHARS)
        pushed += push_random_text();
      wait_idle();
    end

    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- checked_hex_dec_text_to_int_core.f -----
+incdir+src
src/chdti_pkg.sv
src/chdti_front.sv
src/chdti_queue.sv
src/chdti_back.sv
src/checked_hex_dec_text_to_int_core.sv
sim/checked_hex_dec_text_to_int_core_test.sv
